// File: src/sfd_pkg.sv
// sfd_pkg: shared types and constants for the single-precision divider.
// No dependencies; used by the front end, the job queue, the back end and the top level.
package sfd_pkg;

	localparam int MANT_W   = 24;              // mantissa with hidden bit
	localparam int QUOT_W   = 47;              // (mantissa << 23) / mantissa
	localparam int EXP_W    = 11;              // signed working exponent
	localparam int STEP_W   = 6;               // division step counter

	localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
	localparam logic [31:0] INF_BITS  = 32'h7F80_0000;
	localparam logic [31:0] ZERO_BITS = 32'h0000_0000;
	localparam logic signed [EXP_W-1:0] EXP_BIAS = 11'sd127;
	localparam logic signed [EXP_W-1:0] EXP_MAX  = 11'sd255;

	// one classified job passed from front to back
	typedef struct packed {
		logic                      special;   // result already known
		logic [31:0]               spec_res;
		logic                      sign;
		logic signed [EXP_W-1:0]   exp;
		logic [MANT_W-1:0]         man_a;
		logic [MANT_W-1:0]         man_b;
	} job_t;

endpackage

// File: src/sfd_front.sv
// sfd_front: unpacks both operands, settles zero cases, forms the job.
// Depends on sfd_pkg.
module sfd_front (
	input  logic [31:0]   dividend_bits,
	input  logic [31:0]   divisor_bits,
	output sfd_pkg::job_t job
);

	logic                             a_zero, b_zero;
	logic [7:0]                       ea, eb;

	always_comb begin
		a_zero = (dividend_bits[30:0] == 31'd0);
		b_zero = (divisor_bits[30:0] == 31'd0);
		ea     = dividend_bits[30:23];
		eb     = divisor_bits[30:23];

		job.special  = a_zero || b_zero;
		job.spec_res = sfd_pkg::ZERO_BITS;
		if (b_zero) begin
			if (a_zero) begin
				job.spec_res = sfd_pkg::QNAN_BITS;
			end else begin
				job.spec_res = {dividend_bits[31], 31'd0} | sfd_pkg::INF_BITS;
			end
		end
		job.sign  = dividend_bits[31] ^ divisor_bits[31];
		job.exp   = $signed({3'b000, ea}) - $signed({3'b000, eb}) + sfd_pkg::EXP_BIAS;
		job.man_a = {(ea != 8'd0), dividend_bits[22:0]};
		job.man_b = {(eb != 8'd0), divisor_bits[22:0]};
	end

endmodule

// File: src/sfd_queue.sv
// sfd_queue: small FIFO of classified jobs between front and back.
// Depends on sfd_pkg.
module sfd_queue #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sfd_pkg::job_t wr_job,
	input  logic          pop,
	output sfd_pkg::job_t rd_job,
	output logic          full,
	output logic          empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	sfd_pkg::job_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full   = (cnt_q == CNT_W'(DEPTH));
	assign empty  = (cnt_q == '0);
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: src/sfd_back.sv
// sfd_back: radix-2 restoring divider, stepwise normaliser, packer and output register.
// Depends on sfd_pkg.
module sfd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_avail,
	input  sfd_pkg::job_t job,
	output logic          job_pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [31:0]   m_tdata
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_NORM = 2'd2;
	localparam logic [1:0] ST_HOLD = 2'd3;

	localparam int QW = sfd_pkg::QUOT_W;
	localparam int MW = sfd_pkg::MANT_W;
	localparam logic signed [sfd_pkg::EXP_W-1:0] EXP_ONE = sfd_pkg::EXP_W'(1);

	logic [1:0]                        state_q;
	logic [sfd_pkg::STEP_W-1:0]        step_q;
	logic [QW-1:0]                     dq_q;     // dividend bits out, quotient bits in
	logic [MW-1:0]                     rem_q;
	logic [MW-1:0]                     div_q;
	logic signed [sfd_pkg::EXP_W-1:0]  exp_q;
	logic                              sign_q;
	logic [31:0]                       res_q;
	logic                              out_vld_q;
	logic [31:0]                       out_q;

	logic [MW:0]   trial;
	logic          ge;
	logic [MW:0]   diff;
	logic          wide, narrow;
	logic [31:0]   packed_res;
	logic          out_free;

	assign out_free = !out_vld_q || m_tready;
	assign job_pop  = (state_q == ST_IDLE) && job_avail;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

	always_comb begin
		trial  = {rem_q, dq_q[QW-1]};
		ge     = (trial >= {1'b0, div_q});
		diff   = trial - {1'b0, div_q};
		wide   = (dq_q[QW-1:MW] != '0);
		narrow = !dq_q[MW-1] && (exp_q > 0) && (dq_q != '0);
		if (dq_q == '0 || exp_q <= 0) begin
			packed_res = sfd_pkg::ZERO_BITS;
		end else if (exp_q >= sfd_pkg::EXP_MAX) begin
			packed_res = {sign_q, 31'd0} | sfd_pkg::INF_BITS;
		end else begin
			packed_res = {sign_q, exp_q[7:0], dq_q[22:0]};
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (job_avail) begin
					dq_q   <= {job.man_a, 23'd0};
					rem_q  <= '0;
					div_q  <= job.man_b;
					exp_q  <= job.exp;
					sign_q <= job.sign;
					res_q  <= job.spec_res;
					step_q <= sfd_pkg::STEP_W'(QW - 1);
				end
			end
			ST_DIV: begin
				rem_q  <= ge ? diff[MW-1:0] : trial[MW-1:0];
				dq_q   <= {dq_q[QW-2:0], ge};
				step_q <= step_q - 1'b1;
			end
			ST_NORM: begin
				if (wide) begin
					dq_q  <= {1'b0, dq_q[QW-1:1]};
					exp_q <= exp_q + EXP_ONE;
				end else if (narrow) begin
					dq_q  <= {dq_q[QW-2:0], 1'b0};
					exp_q <= exp_q - EXP_ONE;
				end else begin
					res_q <= packed_res;
				end
			end
			default: begin
			end
		endcase
		if (state_q == ST_HOLD && out_free) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (job_avail) begin
						state_q <= job.special ? ST_HOLD : ST_DIV;
					end
				end
				ST_DIV: begin
					if (step_q == '0) begin
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					if (!wide && !narrow) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_HOLD && out_free) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule

// File: src/single_float_divider_top.sv
// Channel   Dir  Fields (tdata, low bit first)
// s_axis    in   dividend_bits[31:0], divisor_bits[63:32]
// m_axis    out  quotient_bits[31:0]
//
// In the back end a division loads the job, runs 47 steps of the restoring divider (one
// quotient bit per cycle), makes up to 23 normalising shifts, packs the result and hands it
// to the output register once that is free. Zero operands skip the divider.
// The front accepts while the job queue has room, so input and output stall independently.
// arst_n clears the queue, the back-end state and the output valid.
//
// Depends on sfd_pkg, sfd_front, sfd_queue, sfd_back.
module single_float_divider_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // dividend_bits, divisor_bits
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // quotient_bits
);

	sfd_pkg::job_t fr_job, q_job;
	logic          q_full, q_empty, q_pop, push;

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	sfd_front u_front (
		.dividend_bits (s_tdata[31:0]),
		.divisor_bits  (s_tdata[63:32]),
		.job           (fr_job)
	);

	sfd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (fr_job),
		.pop    (q_pop),
		.rd_job (q_job),
		.full   (q_full),
		.empty  (q_empty)
	);

	sfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_avail (!q_empty),
		.job       (q_job),
		.job_pop   (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// File: src/sfd_checker.sv
// sfd_checker: port-level checks on the divider, bound to the top level.
// Depends only on the top-level ports.
module sfd_checker #(
	parameter int QUEUE_DEPTH = 2
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [63:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	logic [7:0] pend_q;
	logic       in_acc, out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {7'd0, in_acc} - {7'd0, out_acc};
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 8'd0)
		else $error("result without a pending transaction");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 8'(QUEUE_DEPTH + 2))
		else $error("more transactions in flight than storage");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 8'(QUEUE_DEPTH + 2) |-> !s_tready)
		else $error("input taken with no room");

endmodule

bind single_float_divider_top sfd_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_sfd_checker (.*);
